// ----- sv/rcv_pkg.sv -----
// Shared types, constants and box test for the RGB box color vote block.
package rcv_pkg;

    localparam int PIX_W  = 8;
    localparam int BOX_W  = 48;
    localparam int HITS_W = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values, bytes from low: b_lo, b_hi, g_lo, g_hi, r_lo, r_hi
    localparam logic [BOX_W-1:0] RED_BOX_RESET  = 48'hFA64_380F_3211;
    localparam logic [BOX_W-1:0] BLUE_BOX_RESET = 48'h3204_581F_DC56;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RED_BOX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_BOX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WANT_RED = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [BOX_W-1:0] box_t;

    // Classified pixel handed from the input stage to the tally stage
    typedef struct packed {
        logic valid;
        logic red_hit;
        logic blue_hit;
        logic last;
    } class_t;

    // Open range test on one channel slot of a box
    function automatic logic in_range(input box_t box, input int unsigned slot,
                                      input pix_t v);
        pix_t lo;
        pix_t hi;
        lo = box[16*slot +: PIX_W];
        hi = box[16*slot + PIX_W +: PIX_W];
        return (v > lo) && (v < hi);
    endfunction

    function automatic logic in_box(input box_t box, input pix_t b, input pix_t g,
                                    input pix_t r);
        return in_range(box, 0, b) && in_range(box, 1, g) && in_range(box, 2, r);
    endfunction

endpackage

// ----- sv/rcv_classify.sv -----
// Input stage: box tests on the incoming pixel, registered with the end flag.
module rcv_classify
    import rcv_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  pix_t   s_blue,
    input  pix_t   s_green,
    input  pix_t   s_red,
    input  logic   s_last_of_region,
    input  box_t   red_box,
    input  box_t   blue_box,
    input  logic   take,
    output class_t cls
);

    class_t cls_reg;
    class_t cls_next;
    logic   red_match;
    logic   blue_match;

    // Red has priority when both boxes match
    assign red_match  = in_box(red_box, s_blue, s_green, s_red);
    assign blue_match = in_box(blue_box, s_blue, s_green, s_red);

    assign s_ready = !cls_reg.valid || take;

    always_comb begin
        cls_next = cls_reg;
        if (s_ready) begin
            cls_next.valid    = s_valid;
            cls_next.red_hit  = red_match;
            cls_next.blue_hit = blue_match && !red_match;
            cls_next.last     = s_last_of_region;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_reg <= '0;
        end else begin
            cls_reg <= cls_next;
        end
    end

    assign cls = cls_reg;

endmodule

// ----- sv/rcv_tally.sv -----
// Tally stage: saturating hit counters and the registered verdict word.
module rcv_tally
    import rcv_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  class_t            cls,
    input  logic              want_red,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_red,
    output logic              m_keep,
    output logic [HITS_W-1:0] m_red_hits,
    output logic [HITS_W-1:0] m_blue_hits
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] red_tally_reg, red_tally_next;
    logic [COUNT_BITS-1:0] blue_tally_reg, blue_tally_next;
    logic [COUNT_BITS-1:0] red_upd, blue_upd;
    logic [HITS_W-1:0]     red_rep, blue_rep;
    logic                  verdict;
    logic                  out_free;
    logic                  m_valid_reg, m_valid_next;
    logic                  is_red_reg, keep_reg;
    logic [HITS_W-1:0]     red_hits_reg, blue_hits_reg;

    // A region's last pixel waits only while the previous verdict is unread
    assign out_free = !m_valid_reg || m_ready;
    assign take     = cls.valid && (!cls.last || out_free);

    // Counts including the current pixel
    assign red_upd  = (cls.red_hit && red_tally_reg != CNT_MAX)
                      ? red_tally_reg + COUNT_BITS'(1) : red_tally_reg;
    assign blue_upd = (cls.blue_hit && blue_tally_reg != CNT_MAX)
                      ? blue_tally_reg + COUNT_BITS'(1) : blue_tally_reg;
    assign verdict  = red_upd > blue_upd;

    // Reported counts clip at the output width
    generate
        if (COUNT_BITS > HITS_W) begin : g_clip
            assign red_rep  = |red_upd[COUNT_BITS-1:HITS_W] ? '1 : red_upd[HITS_W-1:0];
            assign blue_rep = |blue_upd[COUNT_BITS-1:HITS_W] ? '1 : blue_upd[HITS_W-1:0];
        end else begin : g_ext
            assign red_rep  = HITS_W'(red_upd);
            assign blue_rep = HITS_W'(blue_upd);
        end
    endgenerate

    always_comb begin
        red_tally_next  = red_tally_reg;
        blue_tally_next = blue_tally_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (take) begin
            if (cls.last) begin
                red_tally_next  = '0;
                blue_tally_next = '0;
                m_valid_next    = 1'b1;
            end else begin
                red_tally_next  = red_upd;
                blue_tally_next = blue_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_tally_reg  <= '0;
            blue_tally_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            red_tally_reg  <= red_tally_next;
            blue_tally_reg <= blue_tally_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result word, loaded on a region's last pixel
    always_ff @(posedge aclk) begin
        if (take && cls.last) begin
            is_red_reg    <= verdict;
            keep_reg      <= (verdict == want_red);
            red_hits_reg  <= red_rep;
            blue_hits_reg <= blue_rep;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_red    = is_red_reg;
    assign m_keep      = keep_reg;
    assign m_red_hits  = red_hits_reg;
    assign m_blue_hits = blue_hits_reg;

endmodule

// ----- sv/rgb_box_color_vote.sv -----
// Top level of the RGB box color vote block: config registers and the two stages.
//
// Takes one BGR pixel per clock, tests it against the red box (priority)
// and the blue box, and counts hits in COUNT_BITS-bit saturating counters.
// On the pixel flagged last_of_region it emits one word: is_red (red count
// strictly above blue), keep (is_red equals want_red) and both counts,
// clipped to 16 bits, then restarts the counts. Throughput is one pixel per
// cycle except while s_ready is low; m_valid is set once the region's last
// pixel is judged out of the input register into the result register.
// s_ready drops only while a region's last pixel sits in the input register
// and the previous verdict word has not been taken. Configuration is written
// through cfg_wr_en, cfg_index and cfg_wdata; the user must write it only while
// no region is in flight, as the block does not enforce this. Index 3 is ignored.
module rgb_box_color_vote
    import rcv_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BOX_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_blue,
    input  logic [PIX_W-1:0]     s_green,
    input  logic [PIX_W-1:0]     s_red,
    input  logic                 s_last_of_region,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_red,
    output logic                 m_keep,
    output logic [HITS_W-1:0]    m_red_hits,
    output logic [HITS_W-1:0]    m_blue_hits
);

    box_t   red_box_reg;
    box_t   blue_box_reg;
    logic   want_red_reg;
    class_t cls;
    logic   take;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_box_reg  <= RED_BOX_RESET;
            blue_box_reg <= BLUE_BOX_RESET;
            want_red_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RED_BOX:  red_box_reg  <= cfg_wdata;
                CFG_BLUE_BOX: blue_box_reg <= cfg_wdata;
                CFG_WANT_RED: want_red_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rcv_classify u_classify (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_blue           (s_blue),
        .s_green          (s_green),
        .s_red            (s_red),
        .s_last_of_region (s_last_of_region),
        .red_box          (red_box_reg),
        .blue_box         (blue_box_reg),
        .take             (take),
        .cls              (cls)
    );

    rcv_tally #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cls         (cls),
        .want_red    (want_red_reg),
        .take        (take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_red    (m_is_red),
        .m_keep      (m_keep),
        .m_red_hits  (m_red_hits),
        .m_blue_hits (m_blue_hits)
    );

endmodule

// ----- sv/rcv_checker.sv -----
// Port-level checks for the RGB box color vote block, bound to the top level.
module rcv_checker
    import rcv_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_is_red,
    input logic                 m_keep,
    input logic [HITS_W-1:0]    m_red_hits,
    input logic [HITS_W-1:0]    m_blue_hits
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // A stalled result word holds
    a_word_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_is_red, m_keep,
                                                    m_red_hits, m_blue_hits}))
        else $error("result word changed while stalled");

    // Verdict agrees with the reported counts
    a_verdict_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_red |-> m_red_hits >= m_blue_hits)
        else $error("red verdict with fewer red hits");

    a_verdict_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_red |-> m_red_hits <= m_blue_hits)
        else $error("blue verdict with more red hits");

    // Input only stalls behind an unread verdict
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result word");

endmodule

bind rgb_box_color_vote rcv_checker u_rcv_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_red    (m_is_red),
    .m_keep      (m_keep),
    .m_red_hits  (m_red_hits),
    .m_blue_hits (m_blue_hits)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the RGB box color vote block.
`timescale 1ns / 1ps

module tb;
    import rcv_pkg::*;

    localparam int COUNT_BITS = 16;
    localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam box_t FULL_BOX = 48'hFF00_FF00_FF00;

    // Ways of picking one channel byte against a box
    typedef enum int unsigned {PICK_INSIDE, PICK_EDGE, PICK_NEAR, PICK_ANY} pick_e;

    typedef struct packed {
        pix_t blue;
        pix_t green;
        pix_t red;
        logic last;
    } pixel_t;

    typedef struct packed {
        logic              is_red;
        logic              keep;
        logic [HITS_W-1:0] red_hits;
        logic [HITS_W-1:0] blue_hits;
    } verdict_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    box_t                 cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pix_t                 s_blue = '0;
    pix_t                 s_green = '0;
    pix_t                 s_red = '0;
    logic                 s_last_of_region = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_is_red;
    logic                 m_keep;
    logic [HITS_W-1:0]    m_red_hits;
    logic [HITS_W-1:0]    m_blue_hits;

    // Pixels waiting to be driven, verdicts waiting to come out
    pixel_t      pixel_q[$];
    verdict_t    verdict_q[$];
    int unsigned pending_pixels = 0;
    int unsigned err_count = 0;

    // Predictor copy of the registers and counters
    box_t            red_box_cfg = RED_BOX_RESET;
    box_t            blue_box_cfg = BLUE_BOX_RESET;
    logic            want_red_cfg = 1'b0;
    longint unsigned red_tally = 0;
    longint unsigned blue_tally = 0;

    // Idling control
    bit          idle_en = 1'b1;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned sink_hold = 0;
    int unsigned hold_req = 0;

    rgb_box_color_vote #(.COUNT_BITS(COUNT_BITS)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_blue          (s_blue),
        .s_green         (s_green),
        .s_red           (s_red),
        .s_last_of_region(s_last_of_region),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_red        (m_is_red),
        .m_keep          (m_keep),
        .m_red_hits      (m_red_hits),
        .m_blue_hits     (m_blue_hits)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (err_count < 100) $display("tb: mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Open range test on all three channels
    function automatic logic box_hit(input box_t box, input pixel_t px);
        pix_t chan [3];
        chan[0] = px.blue;
        chan[1] = px.green;
        chan[2] = px.red;
        for (int s = 0; s < 3; s++)
            if (chan[s] <= box[16*s +: 8] || chan[s] >= box[16*s+8 +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [HITS_W-1:0] clip_hits(input longint unsigned tally);
        return (tally > 64'hFFFF) ? 16'hFFFF : tally[HITS_W-1:0];
    endfunction

    // Count one accepted pixel; close the region on its last pixel
    task automatic tally_pixel(input pixel_t px);
        verdict_t v;
        if (box_hit(red_box_cfg, px)) begin
            if (red_tally < TALLY_MAX) red_tally++;
        end else if (box_hit(blue_box_cfg, px)) begin
            if (blue_tally < TALLY_MAX) blue_tally++;
        end
        if (px.last) begin
            v.is_red    = red_tally > blue_tally;
            v.keep      = (v.is_red == want_red_cfg);
            v.red_hits  = clip_hits(red_tally);
            v.blue_hits = clip_hits(blue_tally);
            verdict_q.insert(verdict_q.size(), v);
            red_tally  = 0;
            blue_tally = 0;
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input box_t data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_RED_BOX:  red_box_cfg = data;
            CFG_BLUE_BOX: blue_box_cfg = data;
            CFG_WANT_RED: want_red_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic push_pixel(input pix_t b, input pix_t g, input pix_t r, input logic last);
        pixel_t px;
        px.blue  = b;
        px.green = g;
        px.red   = r;
        px.last  = last;
        pixel_q.insert(pixel_q.size(), px);
        pending_pixels++;
    endtask

    function automatic pix_t pick_chan(input box_t box, input int slot, input pick_e mode);
        int unsigned lo;
        int unsigned hi;
        lo = box[16*slot +: 8];
        hi = box[16*slot+8 +: 8];
        case (mode)
            PICK_INSIDE: return (hi > lo + 1) ? pix_t'($urandom_range(lo + 1, hi - 1))
                                              : pix_t'($urandom);
            PICK_EDGE:   return pix_t'($urandom_range(0, 1) ? lo : hi);
            PICK_NEAR:   return pix_t'($urandom_range(0, 1) ? lo + 1 : hi - 1);
            default:     return pix_t'($urandom);
        endcase
    endfunction

    // Mostly pixels inside one box, some on the box edges, some noise
    function automatic pixel_t random_pixel();
        pixel_t      px;
        box_t        box;
        pick_e       mode [3];
        int unsigned roll;
        roll = $urandom_range(0, 9);
        box  = (roll < 4) ? red_box_cfg : (roll < 7) ? blue_box_cfg :
               ($urandom_range(0, 1) ? red_box_cfg : blue_box_cfg);
        for (int s = 0; s < 3; s++)
            mode[s] = (roll < 7) ? PICK_INSIDE :
                      (roll < 9) ? pick_e'($urandom_range(0, 2)) : PICK_ANY;
        px.blue  = pick_chan(box, 0, mode[0]);
        px.green = pick_chan(box, 1, mode[1]);
        px.red   = pick_chan(box, 2, mode[2]);
        px.last  = 1'b0;
        return px;
    endfunction

    function automatic box_t random_box();
        box_t        box;
        int unsigned lo;
        int unsigned hi;
        for (int s = 0; s < 3; s++) begin
            if ($urandom_range(0, 7) == 0) begin
                box[16*s +: 16] = 16'($urandom);
            end else begin
                lo = $urandom_range(0, 230);
                hi = lo + $urandom_range(2, 60);
                if (hi > 255) hi = 255;
                box[16*s +: 8]   = lo[7:0];
                box[16*s+8 +: 8] = hi[7:0];
            end
        end
        return box;
    endfunction

    task automatic push_region(input int unsigned len);
        pixel_t px;
        for (int unsigned i = 0; i < len; i++) begin
            px = random_pixel();
            push_pixel(px.blue, px.green, px.red, i == len - 1);
        end
    endtask

    // Wait until every pixel is taken and every verdict is out
    task automatic wait_idle();
        do @(negedge aclk); while (pending_pixels != 0 || verdict_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Pixel driver
    always @(posedge aclk) begin
        pixel_t px;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                px.blue  = s_blue;
                px.green = s_green;
                px.red   = s_red;
                px.last  = s_last_of_region;
                tally_pixel(px);
                pending_pixels--;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    px = pixel_q.pop_front();
                    s_valid          <= 1'b1;
                    s_blue           <= px.blue;
                    s_green          <= px.green;
                    s_red            <= px.red;
                    s_last_of_region <= px.last;
                    if (idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict receiver: random stalls plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req > 0) begin
                sink_hold = hold_req;
                hold_req  = 0;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 13);
            end
        end
    end

    // Verdict checker
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                flag_error("verdict word with none expected");
            end else begin
                want = verdict_q.pop_front();
                if (m_is_red !== want.is_red)
                    flag_error($sformatf("is_red %b, expected %b", m_is_red, want.is_red));
                if (m_keep !== want.keep)
                    flag_error($sformatf("keep %b, expected %b", m_keep, want.keep));
                if (m_red_hits !== want.red_hits)
                    flag_error($sformatf("red_hits %0d, expected %0d",
                                         m_red_hits, want.red_hits));
                if (m_blue_hits !== want.blue_hits)
                    flag_error($sformatf("blue_hits %0d, expected %0d",
                                         m_blue_hits, want.blue_hits));
            end
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned fill;
        int unsigned rlen;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset boxes: misses, hits, exclusive edges, ties
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd17, 8'd16, 8'd101, 1'b0);
        push_pixel(8'd18, 8'd16, 8'd101, 1'b0);
        push_pixel(8'd49, 8'd55, 8'd249, 1'b1);
        push_pixel(8'd87, 8'd32, 8'd5, 1'b0);
        push_pixel(8'd219, 8'd87, 8'd49, 1'b1);
        push_pixel(8'd18, 8'd16, 8'd101, 1'b0);
        push_pixel(8'd87, 8'd32, 8'd5, 1'b1);
        push_pixel(8'd86, 8'd31, 8'd4, 1'b1);
        push_pixel(8'd50, 8'd56, 8'd250, 1'b1);
        wait_idle();

        // Overlapping boxes: red takes priority
        cfg_write(CFG_RED_BOX, FULL_BOX);
        cfg_write(CFG_BLUE_BOX, FULL_BOX);
        cfg_write(CFG_WANT_RED, 48'd1);
        push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
        push_pixel(8'd254, 8'd254, 8'd254, 1'b0);
        push_pixel(8'd0, 8'd5, 8'd5, 1'b1);
        push_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        wait_idle();
        // unused index must not disturb anything
        cfg_write(CFG_UNUSED, '1);
        push_pixel(8'h80, 8'h80, 8'h80, 1'b1);
        wait_idle();

        // Empty boxes never match
        cfg_write(CFG_RED_BOX, '0);
        cfg_write(CFG_BLUE_BOX, 48'h0201_0201_0201);
        cfg_write(CFG_WANT_RED, 48'd0);
        push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
        push_pixel(8'd2, 8'd2, 8'd2, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        wait_idle();

        // Random regions under a series of settings
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    cfg_write(CFG_RED_BOX, FULL_BOX);
                    cfg_write(CFG_BLUE_BOX, FULL_BOX);
                end
                1: begin
                    cfg_write(CFG_RED_BOX, RED_BOX_RESET);
                    cfg_write(CFG_BLUE_BOX, BLUE_BOX_RESET);
                end
                5: begin
                    cfg_write(CFG_RED_BOX, random_box());
                    cfg_write(CFG_BLUE_BOX, '1);
                end
                default: begin
                    cfg_write(CFG_RED_BOX, random_box());
                    cfg_write(CFG_BLUE_BOX, random_box());
                end
            endcase
            cfg_write(CFG_WANT_RED, box_t'({$urandom, $urandom}));
            if (p == 3) hold_req = 400;
            if (p == 7) idle_en = 1'b0;
            fill = 0;
            while (fill < 240) begin
                rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(1, 8);
                push_region(rlen);
                fill += rlen;
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (err_count == 0 && verdict_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
